// ===== rtl/access_code_table_with_time_windows_defines.svh =====
// assertion macros for the access code table
`ifndef ACCESS_CODE_TABLE_WITH_TIME_WINDOWS_DEFINES_SVH
`define ACCESS_CODE_TABLE_WITH_TIME_WINDOWS_DEFINES_SVH

`ifndef SYNTHESIS
`define ACTW_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("access table check failed");
`define ACTW_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("access table check failed");
`else
`define ACTW_ASSERT_IMP(label, ante, cons)
`define ACTW_ASSERT_NXT(label, ante, cons)
`endif

`endif

// ===== rtl/actw_pkg.sv =====
`default_nettype none
package actw_pkg;

	typedef enum logic [2:0] {
		MODE_ADD    = 3'd0,
		MODE_APPEND = 3'd1,
		MODE_DELETE = 3'd2,
		MODE_CLEAR  = 3'd3,
		MODE_LOOKUP = 3'd4
	} mode_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_FULL     = 3'd1,
		ST_DUP      = 3'd2,
		ST_NOTFOUND = 3'd3,
		ST_OUTSIDE  = 3'd4,
		ST_WINREJ   = 3'd5
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN_RD,
		S_SCAN_EV,
		S_WIN_RD,
		S_WIN_EV,
		S_ADD_WR,
		S_APP_RD,
		S_APP_EV,
		S_CP_RD,
		S_CP_EV,
		S_OUT
	} state_t;

	localparam logic [10:0] LAST_MINUTE = 11'd1439;

	// weekday 0 is sunday, mask bit 6; weekday 7 hits no day
	function automatic logic [6:0] day_bit(input logic [2:0] wk);
		logic [6:0] r;
		r = 7'd0;
		if (wk == 3'd0) begin
			r = 7'h40;
		end else if (wk != 3'd7) begin
			r = 7'd1 << (wk - 3'd1);
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/actw_store.sv =====
`default_nettype none
module actw_store #(
	parameter int MAX_ENTRIES = 32,
	parameter int MAX_WINDOWS = 4,
	parameter int TB = 32,
	parameter int VB = 64,
	parameter int IW = 5,
	parameter int AW = 7,
	parameter int NW = 3
) (
	input  wire logic          clk,
	input  wire logic          e_we,
	input  wire logic [IW-1:0] e_waddr,
	input  wire logic [IW-1:0] e_raddr,
	input  wire logic [TB-1:0] e_wtype,
	input  wire logic [VB-1:0] e_wvalue,
	input  wire logic [7:0]    e_wkeypad,
	input  wire logic [7:0]    e_wrelay,
	input  wire logic [NW-1:0] e_wwcnt,
	output logic      [TB-1:0] e_rtype,
	output logic      [VB-1:0] e_rvalue,
	output logic      [7:0]    e_rkeypad,
	output logic      [7:0]    e_rrelay,
	output logic      [NW-1:0] e_rwcnt,
	input  wire logic          w_we,
	input  wire logic [AW-1:0] w_waddr,
	input  wire logic [AW-1:0] w_raddr,
	input  wire logic [10:0]   w_wstart,
	input  wire logic [10:0]   w_wend,
	input  wire logic [6:0]    w_wdays,
	output logic      [10:0]   w_rstart,
	output logic      [10:0]   w_rend,
	output logic      [6:0]    w_rdays
);
	logic [TB-1:0] type_mem   [MAX_ENTRIES];
	logic [VB-1:0] value_mem  [MAX_ENTRIES];
	logic [7:0]    keypad_mem [MAX_ENTRIES];
	logic [7:0]    relay_mem  [MAX_ENTRIES];
	logic [NW-1:0] wcnt_mem   [MAX_ENTRIES];
	logic [10:0]   start_mem  [MAX_ENTRIES*MAX_WINDOWS];
	logic [10:0]   end_mem    [MAX_ENTRIES*MAX_WINDOWS];
	logic [6:0]    days_mem   [MAX_ENTRIES*MAX_WINDOWS];

	always_ff @(posedge clk) begin
		if (e_we) begin
			type_mem[e_waddr]   <= e_wtype;
			value_mem[e_waddr]  <= e_wvalue;
			keypad_mem[e_waddr] <= e_wkeypad;
			relay_mem[e_waddr]  <= e_wrelay;
			wcnt_mem[e_waddr]   <= e_wwcnt;
		end
		e_rtype   <= type_mem[e_raddr];
		e_rvalue  <= value_mem[e_raddr];
		e_rkeypad <= keypad_mem[e_raddr];
		e_rrelay  <= relay_mem[e_raddr];
		e_rwcnt   <= wcnt_mem[e_raddr];
	end

	always_ff @(posedge clk) begin
		if (w_we) begin
			start_mem[w_waddr] <= w_wstart;
			end_mem[w_waddr]   <= w_wend;
			days_mem[w_waddr]  <= w_wdays;
		end
		w_rstart <= start_mem[w_raddr];
		w_rend   <= end_mem[w_raddr];
		w_rdays  <= days_mem[w_raddr];
	end
endmodule
`default_nettype wire

// ===== rtl/actw_win_chk.sv =====
`default_nettype none
module actw_win_chk (
	input  wire logic [10:0] now,
	input  wire logic [6:0]  day_sel,
	input  wire logic [10:0] win_start,
	input  wire logic [10:0] win_end,
	input  wire logic [6:0]  win_days,
	output logic             hit
);
	assign hit = ((win_days & day_sel) != 7'd0) && (now >= win_start) && (now <= win_end);
endmodule
`default_nettype wire

// ===== rtl/access_code_table_with_time_windows.sv =====
// access code table with weekly time windows
// input channel s_*: one transaction per operation, tuser carries the mode
// (add, append window, delete, clear, lookup), tdata the code and time fields.
// output channel m_*: exactly one result transaction per operation, tuser the
// status, tdata granted, relay and the entry count after the operation.
// the block takes one operation at a time; s_tready is low while it works.
// add scans the entries for a duplicate before it writes; delete and lookup
// scan until the code is found; lookup with windows then tries window after
// window, and delete with compaction moves each later entry down one window
// slot a step; the entry and window memories are read one word per step with a
// registered read.
// a finished result sits in the output register; while the receiver stalls it
// holds there and the next result waits in the sequencer, so no input is taken.
// reset empties the table at once (count to zero); stored words are never
// cleared and only entries below the count are read.
`default_nettype none
`include "access_code_table_with_time_windows_defines.svh"
module access_code_table_with_time_windows
	import actw_pkg::*;
#(
	parameter int MAX_ENTRIES = 32,
	parameter int MAX_WINDOWS = 4,
	parameter int TYPE_BITS = 32,
	parameter int VALUE_BITS = 64
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// code_type[31:0] code_value[95:32] keypad_id[103:96] relay_in[111:104]
	// window_start[122:112] window_end[133:123] window_days[140:134]
	// now_hour[145:141] now_minute[151:146] now_weekday[154:152]
	// time_known[155], zero fill to 160
	input  wire logic [159:0] s_tdata,
	// mode[2:0]
	input  wire logic [2:0]   s_tuser,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// granted[0] relay_out[8:1] entry_count[14:9], zero fill to 16
	output logic      [15:0]  m_tdata,
	// status[2:0]
	output logic      [2:0]   m_tuser
);
	localparam int TB = (TYPE_BITS < 32) ? TYPE_BITS : 32;
	localparam int VB = VALUE_BITS;
	localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int AW = (MAX_ENTRIES*MAX_WINDOWS > 1) ? $clog2(MAX_ENTRIES*MAX_WINDOWS) : 1;
	localparam int WW = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
	localparam int NW = $clog2(MAX_WINDOWS + 1);

	state_t state_q, state_d;
	logic [CW-1:0] count_q, count_d;
	logic [IW-1:0] idx_q, idx_d;
	logic [WW-1:0] w_q, w_d;
	logic [2:0]    mode_q;
	logic [TB-1:0] type_q;
	logic [VB-1:0] value_q;
	logic [7:0]    kp_q, relay_q;
	logic [10:0]   ws_q, we_q, now_q;
	logic [6:0]    wd_q, daysel_q;
	logic          known_q;
	logic          res_granted_q, res_granted_d;
	status_t       res_status_q, res_status_d;
	logic [7:0]    res_relay_q, res_relay_d;
	logic          m_valid_q;
	logic [15:0]   m_data_q;
	logic [2:0]    m_user_q;

	logic          s_acc, out_free;
	logic [10:0]   s_ws, s_we, s_now;
	logic [4:0]    s_hr;

	logic          e_we;
	logic [IW-1:0] e_waddr, e_raddr;
	logic [TB-1:0] e_wtype, e_rtype;
	logic [VB-1:0] e_wvalue, e_rvalue;
	logic [7:0]    e_wkeypad, e_rkeypad, e_wrelay, e_rrelay;
	logic [NW-1:0] e_wwcnt, e_rwcnt;
	logic          w_we;
	logic [AW-1:0] w_waddr, w_raddr;
	logic [10:0]   w_rstart, w_rend;
	logic [6:0]    w_rdays;
	logic          win_hit;
	logic [10:0]   wr_start, wr_end;
	logic [6:0]    wr_days;

	logic code_eq, kp_ok, is_last, cp_last, win_last, w_end;

	assign s_tready = (state_q == S_IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign out_free = !m_valid_q || m_tready;
	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_user_q;

	assign s_ws  = s_tdata[122:112];
	assign s_we  = s_tdata[133:123];
	assign s_hr  = s_tdata[145:141];
	// hour*60 + minute, out of range values kept as they are
	assign s_now = {s_hr, 6'd0} - {4'd0, s_hr, 2'd0} + {5'd0, s_tdata[151:146]};

	assign code_eq  = (e_rtype == type_q) && (e_rvalue == value_q);
	assign kp_ok    = (e_rkeypad == 8'd0) || (e_rkeypad == kp_q);
	assign is_last  = (CW'(idx_q) + CW'(1)) == count_q;
	assign cp_last  = (CW'(idx_q) + CW'(2)) == count_q;
	assign win_last = (NW'(w_q) + NW'(1)) == e_rwcnt;
	assign w_end    = (w_q == WW'(MAX_WINDOWS - 1));

	// window data written by the memory comes from the latched input on append,
	// from the read port during compaction
	assign wr_start = (state_q == S_CP_EV) ? w_rstart : ws_q;
	assign wr_end   = (state_q == S_CP_EV) ? w_rend : we_q;
	assign wr_days  = (state_q == S_CP_EV) ? w_rdays : wd_q;

	actw_store #(
		.MAX_ENTRIES(MAX_ENTRIES), .MAX_WINDOWS(MAX_WINDOWS),
		.TB(TB), .VB(VB), .IW(IW), .AW(AW), .NW(NW)
	) u_store (
		.clk(clk),
		.e_we(e_we), .e_waddr(e_waddr), .e_raddr(e_raddr),
		.e_wtype(e_wtype), .e_wvalue(e_wvalue), .e_wkeypad(e_wkeypad),
		.e_wrelay(e_wrelay), .e_wwcnt(e_wwcnt),
		.e_rtype(e_rtype), .e_rvalue(e_rvalue), .e_rkeypad(e_rkeypad),
		.e_rrelay(e_rrelay), .e_rwcnt(e_rwcnt),
		.w_we(w_we), .w_waddr(w_waddr), .w_raddr(w_raddr),
		.w_wstart(wr_start), .w_wend(wr_end), .w_wdays(wr_days),
		.w_rstart(w_rstart), .w_rend(w_rend), .w_rdays(w_rdays)
	);

	actw_win_chk u_win_chk (
		.now(now_q), .day_sel(daysel_q),
		.win_start(w_rstart), .win_end(w_rend), .win_days(w_rdays),
		.hit(win_hit)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (s_acc) begin
					case (s_tuser)
						MODE_ADD: begin
							if (count_q >= CW'(MAX_ENTRIES)) state_d = S_OUT;
							else if (count_q == '0) state_d = S_ADD_WR;
							else state_d = S_SCAN_RD;
						end
						MODE_APPEND: begin
							if (count_q == '0 || s_ws > LAST_MINUTE || s_we > LAST_MINUTE)
								state_d = S_OUT;
							else state_d = S_APP_RD;
						end
						MODE_DELETE, MODE_LOOKUP: begin
							state_d = (count_q == '0) ? S_OUT : S_SCAN_RD;
						end
						default: state_d = S_OUT;
					endcase
				end
			end
			S_SCAN_RD: state_d = S_SCAN_EV;
			S_SCAN_EV: begin
				case (mode_q)
					MODE_ADD: begin
						if (code_eq) state_d = S_OUT;
						else state_d = is_last ? S_ADD_WR : S_SCAN_RD;
					end
					MODE_DELETE: begin
						if (code_eq) state_d = is_last ? S_OUT : S_CP_RD;
						else state_d = is_last ? S_OUT : S_SCAN_RD;
					end
					MODE_LOOKUP: begin
						if (code_eq && kp_ok)
							state_d = (e_rwcnt != '0 && known_q) ? S_WIN_RD : S_OUT;
						else state_d = is_last ? S_OUT : S_SCAN_RD;
					end
					default: state_d = S_OUT;
				endcase
			end
			S_WIN_RD: state_d = S_WIN_EV;
			S_WIN_EV: state_d = (win_hit || win_last) ? S_OUT : S_WIN_RD;
			S_ADD_WR: state_d = S_OUT;
			S_APP_RD: state_d = S_APP_EV;
			S_APP_EV: state_d = S_OUT;
			S_CP_RD:  state_d = S_CP_EV;
			S_CP_EV:  state_d = (w_end && cp_last) ? S_OUT : S_CP_RD;
			S_OUT:    state_d = out_free ? S_IDLE : S_OUT;
			default:  state_d = S_IDLE;
		endcase
	end

	// datapath and memory control
	always_comb begin
		count_d       = count_q;
		idx_d         = idx_q;
		w_d           = w_q;
		res_granted_d = res_granted_q;
		res_status_d  = res_status_q;
		res_relay_d   = res_relay_q;
		e_we          = 1'b0;
		e_waddr       = idx_q;
		e_raddr       = idx_q;
		e_wtype       = e_rtype;
		e_wvalue      = e_rvalue;
		e_wkeypad     = e_rkeypad;
		e_wrelay      = e_rrelay;
		e_wwcnt       = e_rwcnt;
		w_we          = 1'b0;
		w_waddr       = AW'(idx_q * MAX_WINDOWS + w_q);
		w_raddr       = AW'(idx_q * MAX_WINDOWS + w_q);
		case (state_q)
			S_IDLE: begin
				idx_d         = '0;
				w_d           = '0;
				res_granted_d = 1'b0;
				res_status_d  = ST_OK;
				res_relay_d   = 8'd0;
				if (s_acc) begin
					case (s_tuser)
						MODE_ADD: begin
							if (count_q >= CW'(MAX_ENTRIES)) res_status_d = ST_FULL;
						end
						MODE_APPEND: begin
							if (count_q == '0 || s_ws > LAST_MINUTE || s_we > LAST_MINUTE)
								res_status_d = ST_WINREJ;
						end
						MODE_DELETE, MODE_LOOKUP: begin
							if (count_q == '0) res_status_d = ST_NOTFOUND;
						end
						MODE_CLEAR: begin
							count_d       = '0;
							res_granted_d = 1'b1;
						end
						default: ;
					endcase
				end
			end
			S_SCAN_EV: begin
				case (mode_q)
					MODE_ADD: begin
						if (code_eq) res_status_d = ST_DUP;
						else if (!is_last) idx_d = idx_q + IW'(1);
					end
					MODE_DELETE: begin
						if (code_eq) begin
							if (is_last) begin
								count_d       = count_q - CW'(1);
								res_granted_d = 1'b1;
							end
						end else if (is_last) begin
							res_status_d = ST_NOTFOUND;
						end else begin
							idx_d = idx_q + IW'(1);
						end
					end
					MODE_LOOKUP: begin
						if (code_eq && kp_ok) begin
							if (!(e_rwcnt != '0 && known_q)) begin
								res_granted_d = 1'b1;
								res_relay_d   = e_rrelay;
							end
						end else if (is_last) begin
							res_status_d = ST_NOTFOUND;
						end else begin
							idx_d = idx_q + IW'(1);
						end
					end
					default: ;
				endcase
			end
			S_WIN_EV: begin
				// entry read address still points at the matched entry
				if (win_hit) begin
					res_granted_d = 1'b1;
					res_relay_d   = e_rrelay;
				end else if (win_last) begin
					res_status_d = ST_OUTSIDE;
				end else begin
					w_d = w_q + WW'(1);
				end
			end
			S_ADD_WR: begin
				e_we          = 1'b1;
				e_waddr       = IW'(count_q);
				e_wtype       = type_q;
				e_wvalue      = value_q;
				e_wkeypad     = kp_q;
				e_wrelay      = relay_q;
				e_wwcnt       = '0;
				count_d       = count_q + CW'(1);
				res_granted_d = 1'b1;
			end
			S_APP_RD: begin
				e_raddr = IW'(count_q - CW'(1));
			end
			S_APP_EV: begin
				e_raddr = IW'(count_q - CW'(1));
				e_waddr = IW'(count_q - CW'(1));
				if (e_rwcnt >= NW'(MAX_WINDOWS)) begin
					res_status_d = ST_WINREJ;
				end else begin
					e_we          = 1'b1;
					e_wwcnt       = e_rwcnt + NW'(1);
					w_we          = 1'b1;
					w_waddr       = AW'(IW'(count_q - CW'(1)) * MAX_WINDOWS + e_rwcnt);
					res_granted_d = 1'b1;
				end
			end
			S_CP_RD: begin
				e_raddr = idx_q + IW'(1);
				w_raddr = AW'((idx_q + IW'(1)) * MAX_WINDOWS + w_q);
			end
			S_CP_EV: begin
				// move entry idx+1 down to idx, one window slot a step
				e_raddr = idx_q + IW'(1);
				e_we    = 1'b1;
				w_we    = 1'b1;
				if (w_end) begin
					w_d = '0;
					if (cp_last) begin
						count_d       = count_q - CW'(1);
						res_granted_d = 1'b1;
					end else begin
						idx_d = idx_q + IW'(1);
					end
				end else begin
					w_d = w_q + WW'(1);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (state_q == S_OUT && out_free) m_valid_q <= 1'b1;
			else if (m_tready) m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		idx_q         <= idx_d;
		w_q           <= w_d;
		res_granted_q <= res_granted_d;
		res_status_q  <= res_status_d;
		res_relay_q   <= res_relay_d;
		if (s_acc) begin
			mode_q   <= s_tuser;
			type_q   <= s_tdata[TB-1:0];
			value_q  <= s_tdata[32 +: VB];
			kp_q     <= s_tdata[103:96];
			relay_q  <= s_tdata[111:104];
			ws_q     <= s_ws;
			we_q     <= s_we;
			wd_q     <= s_tdata[140:134];
			now_q    <= s_now;
			daysel_q <= day_bit(s_tdata[154:152]);
			known_q  <= s_tdata[155];
		end
		if (state_q == S_OUT && out_free) begin
			m_data_q <= {1'b0, 6'(count_q), res_relay_q, res_granted_q};
			m_user_q <= res_status_q;
		end
	end

	`ACTW_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CW'(MAX_ENTRIES))
	`ACTW_ASSERT_NXT(a_busy_after_accept, s_acc, !s_tready)
	`ACTW_ASSERT_IMP(a_grant_ok, m_tvalid && m_tdata[0], m_tuser == ST_OK)
	`ACTW_ASSERT_IMP(a_relay_only_granted, m_tvalid && !m_tdata[0], m_tdata[8:1] == 8'd0)
endmodule
`default_nettype wire

// ===== bench/actw_checker.sv =====
`timescale 1ns / 1ps
module actw_checker
	import actw_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	input  wire logic         s_tready,
	input  wire logic [159:0] s_tdata,
	input  wire logic [2:0]   s_tuser,
	input  wire logic         m_tvalid,
	input  wire logic         m_tready,
	input  wire logic [15:0]  m_tdata,
	input  wire logic [2:0]   m_tuser,
	output int                fail_count,
	output int                pending,
	output int                result_count
);
	localparam int NE = 32;
	localparam int NW = 4;

	typedef struct packed {
		logic       granted;
		logic [2:0] status;
		logic [7:0] relay;
		logic [5:0] count;
	} verdict_t;

	logic [31:0] tbl_type [NE];
	logic [63:0] tbl_value [NE];
	logic [7:0]  tbl_keypad [NE];
	logic [7:0]  tbl_relay [NE];
	int          tbl_nwin [NE];
	logic [10:0] win_lo [NE][NW];
	logic [10:0] win_hi [NE][NW];
	logic [6:0]  win_days [NE][NW];
	int          held;
	verdict_t    verdicts [$];

	assign pending = verdicts.size();

	function automatic int find_code(logic [31:0] t, logic [63:0] v);
		for (int i = 0; i < held; i++)
			if (tbl_type[i] == t && tbl_value[i] == v) return i;
		return -1;
	endfunction

	task automatic apply_operation(input logic [2:0] md, input logic [159:0] d);
		logic [31:0] t;
		logic [63:0] v;
		logic [7:0]  kp, rl;
		logic [10:0] ws, we;
		logic [6:0]  wd, dbit;
		logic [4:0]  hr;
		logic [5:0]  mn;
		logic [2:0]  wk;
		logic        known, hit;
		int          idx, e, nowm;
		verdict_t    r;
		t = d[31:0]; v = d[95:32]; kp = d[103:96]; rl = d[111:104];
		ws = d[122:112]; we = d[133:123]; wd = d[140:134];
		hr = d[145:141]; mn = d[151:146]; wk = d[154:152]; known = d[155];
		r = '0;
		r.status = ST_OK;
		case (md)
			MODE_ADD: begin
				if (held >= NE) r.status = ST_FULL;
				else if (find_code(t, v) >= 0) r.status = ST_DUP;
				else begin
					tbl_type[held] = t; tbl_value[held] = v;
					tbl_keypad[held] = kp; tbl_relay[held] = rl;
					tbl_nwin[held] = 0;
					held++;
					r.granted = 1;
				end
			end
			MODE_APPEND: begin
				if (held == 0 || ws > LAST_MINUTE || we > LAST_MINUTE ||
						tbl_nwin[held-1] >= NW) begin
					r.status = ST_WINREJ;
				end else begin
					e = held - 1;
					win_lo[e][tbl_nwin[e]] = ws;
					win_hi[e][tbl_nwin[e]] = we;
					win_days[e][tbl_nwin[e]] = wd;
					tbl_nwin[e]++;
					r.granted = 1;
				end
			end
			MODE_DELETE: begin
				idx = find_code(t, v);
				if (idx < 0) r.status = ST_NOTFOUND;
				else begin
					for (int i = idx; i + 1 < held; i++) begin
						tbl_type[i] = tbl_type[i+1]; tbl_value[i] = tbl_value[i+1];
						tbl_keypad[i] = tbl_keypad[i+1]; tbl_relay[i] = tbl_relay[i+1];
						tbl_nwin[i] = tbl_nwin[i+1];
						win_lo[i] = win_lo[i+1]; win_hi[i] = win_hi[i+1];
						win_days[i] = win_days[i+1];
					end
					held--;
					r.granted = 1;
				end
			end
			MODE_CLEAR: begin
				held = 0;
				r.granted = 1;
			end
			MODE_LOOKUP: begin
				r.status = ST_NOTFOUND;
				dbit = (wk == 0) ? 7'h40 : (wk == 7 ? 7'h00 : 7'h01 << (wk - 1));
				nowm = int'(hr) * 60 + int'(mn);
				for (int i = 0; i < held; i++) begin
					if (tbl_type[i] != t || tbl_value[i] != v) continue;
					if (tbl_keypad[i] != 0 && tbl_keypad[i] != kp) continue;
					if (tbl_nwin[i] > 0 && known) begin
						hit = 0;
						for (int w = 0; w < tbl_nwin[i]; w++)
							if ((win_days[i][w] & dbit) != 0 && nowm >= win_lo[i][w] &&
									nowm <= win_hi[i][w]) hit = 1;
						if (!hit) begin
							r.status = ST_OUTSIDE;
							break;
						end
					end
					r.granted = 1;
					r.status = ST_OK;
					r.relay = tbl_relay[i];
					break;
				end
			end
			default: ;
		endcase
		r.count = held[5:0];
		verdicts.push_back(r);
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch on result %0d: %s got %0d expected %0d",
			result_count, what, got, want);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		result_count = 0;
		held = 0;
	end

	always @(posedge clk) begin
		verdict_t w;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (verdicts.size() == 0) begin
					report_mismatch("unexpected transaction", 1, 0);
				end else begin
					w = verdicts.pop_front();
					if (m_tdata[0] !== w.granted) report_mismatch("granted", m_tdata[0], w.granted);
					if (m_tuser !== w.status) report_mismatch("status", m_tuser, w.status);
					if (m_tdata[8:1] !== w.relay) report_mismatch("relay", m_tdata[8:1], w.relay);
					if (m_tdata[14:9] !== w.count) report_mismatch("count", m_tdata[14:9], w.count);
					if (m_tdata[15] !== 1'b0) report_mismatch("fill bit", m_tdata[15], 0);
				end
				result_count++;
			end
			if (s_tvalid && s_tready) apply_operation(s_tuser, s_tdata);
		end
	end
endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
	import actw_pkg::*;

	logic         clk = 0;
	logic         arst_n = 0;
	logic         s_tvalid = 0;
	logic         s_tready;
	logic [159:0] s_tdata = '0;
	logic [2:0]   s_tuser = '0;
	logic         m_tvalid;
	logic         m_tready = 0;
	logic [15:0]  m_tdata;
	logic [2:0]   m_tuser;
	int           fail_count, pending, result_count;
	int           cycles = 0;
	int           sent = 0;
	bit           calm = 0;
	bit           long_hold = 0;

	// a small pool of codes so that duplicates, deletes and lookups hit
	logic [31:0]  pool_type [8];
	logic [63:0]  pool_value [8];

	always #5 clk = ~clk;

	access_code_table_with_time_windows u_top (.*);

	actw_checker u_chk (.*);

	always @(posedge clk) begin
		cycles++;
		if (cycles > 2000000) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// receiver: random bursts of stall, one long hold-off on request
	initial begin
		int n;
		forever begin
			@(negedge clk);
			if (long_hold) begin
				m_tready <= 0;
				for (n = 0; n < 400; n++) @(negedge clk);
				long_hold = 0;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				m_tready <= 0;
				n = $urandom_range(1, 4);
				repeat (n - 1) @(negedge clk);
			end else begin
				m_tready <= 1;
			end
		end
	end

	// returns at the accepting edge; valid drops or moves on at the next falling edge
	task automatic send_op(input logic [2:0] md, input logic [159:0] d);
		int g;
		@(negedge clk);
		if (!calm && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 0;
			g = $urandom_range(1, 4);
			repeat (g) @(negedge clk);
		end
		s_tvalid <= 1;
		s_tuser <= md;
		s_tdata <= d;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sent++;
	endtask

	task automatic release_in();
		@(negedge clk);
		s_tvalid <= 0;
	endtask

	function automatic logic [159:0] pack_op(logic [31:0] t, logic [63:0] v,
			logic [7:0] kp, logic [7:0] rl, logic [10:0] ws, logic [10:0] we,
			logic [6:0] wd, logic [4:0] hr, logic [5:0] mn, logic [2:0] wk, logic kn);
		return {4'd0, kn, wk, mn, hr, wd, we, ws, rl, kp, v, t};
	endfunction

	function automatic logic [159:0] rand_op(bit from_pool);
		int p;
		logic [31:0] t;
		logic [63:0] v;
		p = $urandom_range(0, 7);
		t = from_pool ? pool_type[p] : $urandom;
		v = from_pool ? pool_value[p] : {$urandom, $urandom};
		return pack_op(t, v, ($urandom_range(0, 2) == 0) ? 8'd0 : 8'($urandom_range(0, 3)),
			8'($urandom), ($urandom_range(0, 9) == 0) ? 11'($urandom) : 11'($urandom_range(0, 1439)),
			($urandom_range(0, 9) == 0) ? 11'($urandom) : 11'($urandom_range(0, 1439)),
			7'($urandom), ($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'($urandom_range(0, 23)),
			($urandom_range(0, 9) == 0) ? 6'($urandom) : 6'($urandom_range(0, 59)),
			3'($urandom), 1'($urandom_range(0, 4) != 0));
	endfunction

	initial begin
		int k, wait_n;
		logic [2:0] md;
		for (k = 0; k < 8; k++) begin
			pool_type[k] = $urandom;
			pool_value[k] = {$urandom, $urandom};
		end
		pool_type[0] = '1; pool_value[0] = '1;
		pool_type[1] = '0; pool_value[1] = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;
		@(negedge clk);

		// directed: empty table cases, extremes, windows, duplicates, full
		send_op(MODE_APPEND, pack_op(0, 0, 0, 0, 0, 0, 7'h7f, 0, 0, 0, 1));
		send_op(MODE_LOOKUP, pack_op('1, '1, 0, 0, 0, 0, 0, 0, 0, 0, 1));
		send_op(MODE_DELETE, pack_op('1, '1, 0, 0, 0, 0, 0, 0, 0, 0, 1));
		send_op(MODE_ADD, pack_op('1, '1, 8'd0, 8'hff, 0, 0, 0, 0, 0, 0, 1));
		send_op(MODE_ADD, pack_op('1, '1, 8'd1, 8'h11, 0, 0, 0, 0, 0, 0, 1));
		send_op(MODE_APPEND, pack_op(0, 0, 0, 0, 11'd0, 11'd1439, 7'h40, 0, 0, 0, 1));
		send_op(MODE_APPEND, pack_op(0, 0, 0, 0, 11'd1440, 11'd10, 7'h7f, 0, 0, 0, 1));
		send_op(MODE_APPEND, pack_op(0, 0, 0, 0, 11'd10, 11'h7ff, 7'h7f, 0, 0, 0, 1));
		send_op(MODE_APPEND, pack_op(0, 0, 0, 0, 11'd600, 11'd660, 7'h01, 0, 0, 0, 1));
		send_op(MODE_APPEND, pack_op(0, 0, 0, 0, 11'd5, 11'd6, 7'h00, 0, 0, 0, 1));
		send_op(MODE_APPEND, pack_op(0, 0, 0, 0, 11'd1439, 11'd1439, 7'h7f, 0, 0, 0, 1));
		send_op(MODE_APPEND, pack_op(0, 0, 0, 0, 11'd0, 11'd0, 7'h7f, 0, 0, 0, 1));
		send_op(MODE_LOOKUP, pack_op('1, '1, 8'hff, 0, 0, 0, 0, 5'd23, 6'd59, 3'd0, 1));
		send_op(MODE_LOOKUP, pack_op('1, '1, 8'h07, 0, 0, 0, 0, 5'd10, 6'd30, 3'd1, 1));
		send_op(MODE_LOOKUP, pack_op('1, '1, 8'h07, 0, 0, 0, 0, 5'd3, 6'd0, 3'd7, 1));
		send_op(MODE_LOOKUP, pack_op('1, '1, 8'h07, 0, 0, 0, 0, 5'd3, 6'd0, 3'd7, 0));
		send_op(MODE_LOOKUP, pack_op('1, '1, 8'h07, 0, 0, 0, 0, 5'd31, 6'd63, 3'd2, 1));
		send_op(3'd5, pack_op('1, '1, 0, 0, 0, 0, 0, 0, 0, 0, 1));
		send_op(3'd7, pack_op('1, '1, 0, 0, 0, 0, 0, 0, 0, 0, 1));
		for (k = 0; k < 33; k++)
			send_op(MODE_ADD, pack_op(k, {$urandom, $urandom}, 8'(k), 8'(k + 1),
				0, 0, 0, 0, 0, 0, 1));
		send_op(MODE_DELETE, pack_op('1, '1, 0, 0, 0, 0, 0, 0, 0, 0, 1));
		send_op(MODE_CLEAR, '0);

		// random: mostly pool codes so the table sees hits, windows and deletes
		for (k = 0; k < 1000; k++) begin
			if (k == 300) long_hold = 1;
			if (k == 500) begin
				release_in();
				while (pending != 0) @(negedge clk);
			end
			if (k == 850) calm = 1;
			wait_n = $urandom_range(0, 99);
			if (wait_n < 25) md = MODE_ADD;
			else if (wait_n < 45) md = MODE_APPEND;
			else if (wait_n < 55) md = MODE_DELETE;
			else if (wait_n < 57) md = MODE_CLEAR;
			else if (wait_n < 97) md = MODE_LOOKUP;
			else md = 3'($urandom_range(5, 7));
			send_op(md, rand_op($urandom_range(0, 9) != 0));
		end
		release_in();

		wait_n = 0;
		while (pending != 0 && wait_n < 100000) begin
			@(negedge clk);
			wait_n++;
		end
		repeat (300) @(negedge clk);
		$display("ran %0d operations and checked %0d results, directed then random", sent,
			result_count);
		$display("covered full table, duplicates, window limits, deletes and lookups");
		if (fail_count == 0 && pending == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/actw_pkg.sv
rtl/actw_store.sv
rtl/actw_win_chk.sv
rtl/access_code_table_with_time_windows.sv
bench/actw_checker.sv
bench/tb_top.sv
